@@ sv/wps_pkg.sv @@
`default_nettype none
package wps_pkg;

  localparam int MAX_WAVES = 16;
  localparam int IDX_W     = $clog2(MAX_WAVES);
  localparam int CNT_W     = $clog2(MAX_WAVES + 1);
  localparam int ID_W      = 4;
  localparam int NUM_IDS   = 1 << ID_W;
  localparam int STAMP_W   = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  localparam logic POL_RR     = 1'b0;
  localparam logic POL_GREEDY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/wavefront_pool_scheduler.sv @@
// Add, or schedule on an empty pool: ST_IDLE goes to ST_DONE, which loads the result register.
// Schedule on a non-empty pool: ST_SCAN comes between them and visits n pool entries, one per cycle
// (round-robin stops at the first eligible one, else visits all; greedy visits all), 1 to 16.
// The next word is taken only once the state is back in ST_IDLE.
// A held result word lets the next item in but delays its result until the word leaves.
// Reset (rst, synchronous): empty pool, cursor at head, stamps zero, round-robin, no result.
`default_nettype none
module wavefront_pool_scheduler (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_wdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // wave_id[3:0], running_mask[19:4], fetch_busy_mask[35:20], now_cycle[67:36], zero
  input  wire logic [wps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // granted[0], granted_id[4:1], add_dropped[5], zero
  output logic [wps_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import wps_pkg::*;

  state_t state, state_next;

  logic                  policy;
  logic                  op;
  logic [ID_W-1:0]       wave_id;
  logic [NUM_IDS-1:0]    run_mask;
  logic [NUM_IDS-1:0]    busy_mask;
  logic [STAMP_W-1:0]    now_cycle;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cursor;
  logic [STAMP_W-1:0]    stamp [NUM_IDS];

  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      k;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [ID_W-1:0]       pick_id;
  logic [STAMP_W-1:0]    best_stamp;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  cell_ctrl_t            ctrl     [MAX_WAVES];
  logic [ID_W-1:0]       cell_id  [MAX_WAVES];
  logic [MAX_WAVES-1:0]  cell_elig;

  logic                  in_accept;
  logic                  out_free;
  logic                  finish;
  logic                  cur_elig;
  logic [ID_W-1:0]       cur_id;
  logic                  last_k;
  logic                  scan_stop;
  logic [CNT_W-1:0]      idx_inc;
  logic                  do_append;
  logic                  do_remove;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign out_free  = ~out_valid | m_axis_tready;
  assign finish    = (state == ST_DONE) & out_free;
  assign cur_id    = cell_id[idx];
  assign cur_elig  = cell_elig[idx];
  assign last_k    = (k == count - CNT_W'(1));
  assign scan_stop = last_k | ((policy == POL_RR) & cur_elig);
  assign idx_inc   = {1'b0, idx} + CNT_W'(1);
  assign do_append = finish & (op == OP_ADD) & (count != CNT_W'(MAX_WAVES));
  assign do_remove = finish & (op == OP_SCHED) & found;

  // cell chain
  for (genvar i = 0; i < MAX_WAVES; i++) begin : g_cell
    logic [ID_W-1:0] nbr_id;
    if (i == MAX_WAVES - 1) begin : g_tail
      assign nbr_id = '0;
    end else begin : g_mid
      assign nbr_id = cell_id[i+1];
    end
    assign ctrl[i].load  = do_append & (count == CNT_W'(i));
    assign ctrl[i].shift = do_remove & (IDX_W'(i) >= pick);
    wps_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .load_id   (wave_id),
      .next_id   (nbr_id),
      .run_mask  (run_mask),
      .busy_mask (busy_mask),
      .id        (cell_id[i]),
      .eligible  (cell_elig[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == OP_ADD || count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_stop) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_RR;
    end else if (cfg_we) begin
      policy <= cfg_wdata;
    end
  end

  // latch item and run the scan
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op        <= s_axis_tuser;
      wave_id   <= s_axis_tdata[3:0];
      run_mask  <= s_axis_tdata[19:4];
      busy_mask <= s_axis_tdata[35:20];
      now_cycle <= s_axis_tdata[67:36];
      found     <= 1'b0;
      k         <= '0;
      if (policy == POL_GREEDY || cursor >= count) begin
        idx <= '0;
      end else begin
        idx <= cursor[IDX_W-1:0];
      end
    end else if (state == ST_SCAN) begin
      k <= k + CNT_W'(1);
      if (idx_inc == count) begin
        idx <= '0;
      end else begin
        idx <= idx_inc[IDX_W-1:0];
      end
      if (cur_elig && (policy == POL_RR || !found || stamp[cur_id] > best_stamp)) begin
        found      <= 1'b1;
        pick       <= idx;
        pick_id    <= cur_id;
        best_stamp <= stamp[cur_id];
      end
    end
  end

  // pool bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
      for (int i = 0; i < NUM_IDS; i++) begin
        stamp[i] <= '0;
      end
    end else begin
      if (in_accept && s_axis_tuser == OP_SCHED && count != '0 &&
          policy == POL_RR && cursor >= count) begin
        cursor <= '0;
      end
      if (do_append) begin
        count <= count + CNT_W'(1);
      end
      if (do_remove) begin
        count  <= count - CNT_W'(1);
        cursor <= CNT_W'(pick);
        if (policy == POL_GREEDY) begin
          stamp[pick_id] <= now_cycle;
        end
      end else if (finish && op == OP_SCHED && count != '0 && policy == POL_GREEDY) begin
        cursor <= count;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data[0]   <= (op == OP_SCHED) & found;
      out_data[4:1] <= ((op == OP_SCHED) && found) ? pick_id : '0;
      out_data[5]   <= (op == OP_ADD) & (count == CNT_W'(MAX_WAVES));
      out_data[OUT_DATA_W-1:6] <= '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
`default_nettype wire

@@ sv/wps_cell.sv @@
`default_nettype none
module wps_cell (
  input  wire logic                          clk,
  input  wire wps_pkg::cell_ctrl_t           ctrl,
  input  wire logic [wps_pkg::ID_W-1:0]      load_id,
  input  wire logic [wps_pkg::ID_W-1:0]      next_id,
  input  wire logic [wps_pkg::NUM_IDS-1:0]   run_mask,
  input  wire logic [wps_pkg::NUM_IDS-1:0]   busy_mask,
  output logic [wps_pkg::ID_W-1:0]           id,
  output logic                               eligible
);
  import wps_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id <= load_id;
    end else if (ctrl.shift) begin
      id <= next_id;
    end
  end

  assign eligible = run_mask[id] & ~busy_mask[id];

endmodule
`default_nettype wire

@@ sv/wps_checker.sv @@
`default_nettype none
module wps_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [wps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import wps_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // grant and drop never together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[5]))
    else $error("grant and drop in one word");

  // id is zero without a grant
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == '0)
    else $error("nonzero id without grant");

  // busy the cycle after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while working");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result pending after reset");

endmodule

bind wavefront_pool_scheduler wps_checker u_wps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
